### hw/rtl/nts_pkg.sv
// Package for the modulo-12289 NTT twiddle stage: widths, reduction constants,
// twiddle tables and the control struct shared by the control and top files.
// No dependencies.
`default_nettype none

package nts_pkg;

   localparam int LANES   = 8;
   localparam int COLS    = 4;
   localparam int IN_W    = 32;
   localparam int OUT_W   = 15;
   localparam int RED_W   = 16;
   localparam int TW_W    = 14;
   localparam int SHP_W   = 30;
   localparam int GRP_W   = 2;
   localparam int IN_BUS  = 256;
   localparam int OUT_BUS = 120;

   localparam logic [13:0] MOD_Q     = 14'd12289;
   localparam logic [18:0] BARRETT_R = 19'd349496;

   // Twiddle values and their Shoup constants floor(w * 2^30 / q), by group and column.
   localparam logic [TW_W-1:0] TW_VAL [COLS][COLS] = '{
      '{14'd1, 14'd1,    14'd1,     14'd1},
      '{14'd1, 14'd7506, 14'd4134,  14'd7260},
      '{14'd1, 14'd7260, 14'd8246,  14'd79},
      '{14'd1, 14'd4134, 14'd11567, 14'd8246}
   };

   localparam logic [SHP_W-1:0] TW_SHOUP [COLS][COLS] = '{
      '{30'd87374, 30'd87374,     30'd87374,      30'd87374},
      '{30'd87374, 30'd655830916, 30'd361205037,  30'd634336857},
      '{30'd87374, 30'd634336857, 30'd720487841,  30'd6902563},
      '{30'd87374, 30'd361205037, 30'd1010657635, 30'd720487841}
   };

   localparam logic [GRP_W-1:0] GRP_PASS = 2'd0;

   typedef struct packed {
      logic             en;
      logic [GRP_W-1:0] grp_s2;
      logic             vld_s3;
      logic [GRP_W-1:0] grp_cnt;
   } nts_ctrl_type;

endpackage

`default_nettype wire

### hw/rtl/nts_lane.sv
// One coefficient lane: Barrett reduction followed by the Shoup twiddle multiply,
// in four register stages that all advance on the shared enable. Uses nts_pkg.
`default_nettype none

module nts_lane
   import nts_pkg::*;
(
   input  wire                     clock,
   input  wire                     en,
   input  wire  signed [IN_W-1:0]  x,
   input  wire         [TW_W-1:0]  w,
   input  wire         [SHP_W-1:0] wp,
   input  wire                     pass,
   output logic        [OUT_W-1:0] y
);

   localparam logic [RED_W-1:0] Q16 = RED_W'(MOD_Q);
   localparam logic [OUT_W-1:0] Q15 = OUT_W'(MOD_Q);

   logic signed [51:0]       bprod_c;
   logic        [RED_W-1:0]  t_ff, t_in;
   logic        [RED_W-1:0]  xl_ff, xl_in;
   logic        [RED_W-1:0]  qt_c;
   logic signed [RED_W-1:0]  r_ff, r_in;
   logic signed [46:0]       sprod_c;
   logic        [OUT_W-1:0]  s_ff, s_in;
   logic        [OUT_W-1:0]  rw_ff, rw_in;
   logic        [OUT_W-1:0]  rp_ff, rp_in;
   logic                     pass_ff, pass_in;
   logic        [OUT_W-1:0]  qs_c;
   logic        [OUT_W-1:0]  y_ff, y_in;

   // The reduced value lies in [-q, 2q), so its low 16 bits hold it exactly;
   // only the low bits of the quotient estimate are needed to form it.
   assign bprod_c = x * $signed({1'b0, BARRETT_R});
   assign t_in    = bprod_c[47:32];
   assign xl_in   = x[RED_W-1:0];

   assign qt_c    = RED_W'(t_ff * Q16);
   assign r_in    = $signed(xl_ff - qt_c);

   assign sprod_c = r_ff * $signed({1'b0, wp});
   assign s_in    = sprod_c[44:30];
   assign rw_in   = OUT_W'(r_ff[OUT_W-1:0] * {1'b0, w});
   assign rp_in   = r_ff[OUT_W-1:0];
   assign pass_in = pass;

   assign qs_c    = OUT_W'(s_ff * Q15);
   assign y_in    = pass_ff ? rp_ff : OUT_W'(rw_ff - qs_c);

   always_ff @(posedge clock) begin
      if (en) begin
         t_ff    <= t_in;
         xl_ff   <= xl_in;
         r_ff    <= r_in;
         s_ff    <= s_in;
         rw_ff   <= rw_in;
         rp_ff   <= rp_in;
         pass_ff <= pass_in;
         y_ff    <= y_in;
      end
   end

   assign y = y_ff;

endmodule

`default_nettype wire

### hw/rtl/nts_ctrl.sv
// Control for the twiddle stage: group counter, valid bits of the four pipeline
// stages and the common stall enable. Uses nts_pkg.
`default_nettype none

module nts_ctrl
   import nts_pkg::*;
(
   input  wire          clock,
   input  wire          reset,
   input  wire          in_valid,
   input  wire          out_ready,
   output logic         in_ready,
   output logic         out_valid,
   output nts_ctrl_type ctrl
);

   logic             en;
   logic             acc;
   logic [GRP_W-1:0] cnt_ff, cnt_in;
   logic [GRP_W-1:0] grp1_ff, grp1_in;
   logic [GRP_W-1:0] grp2_ff, grp2_in;
   logic [4:1]       vld_ff, vld_in;

   // The whole pipeline holds only while a finished item waits at the output.
   assign en      = !vld_ff[4] || out_ready;
   assign acc     = in_valid && en;

   assign cnt_in  = acc ? GRP_W'(cnt_ff + 1'b1) : cnt_ff;
   assign grp1_in = en ? cnt_ff : grp1_ff;
   assign grp2_in = en ? grp1_ff : grp2_ff;
   assign vld_in  = en ? {vld_ff[3:1], acc} : vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         vld_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      grp1_ff <= grp1_in;
      grp2_ff <= grp2_in;
   end

   assign in_ready     = en;
   assign out_valid    = vld_ff[4];
   assign ctrl.en      = en;
   assign ctrl.grp_s2  = grp2_ff;
   assign ctrl.vld_s3  = vld_ff[3];
   assign ctrl.grp_cnt = cnt_ff;

endmodule

`default_nettype wire

### hw/rtl/ntt_twiddle_stage_mod_q.sv
// Top level of the modulo-12289 NTT twiddle stage: eight nts_lane copies, the
// nts_ctrl control block and the merge of the lane results. Uses nts_pkg.
//
// Each item carries eight signed 32-bit coefficients and returns eight 15-bit
// results in the same lane order. Every lane is Barrett-reduced modulo 12289;
// items of group 0 pass the reduced values, groups 1 to 3 multiply by a fixed
// twiddle per lane using Shoup reduction. The group counts 0 to 3 over accepted
// items, starting from 0 after reset. The block takes one item per clock while it
// is not stalled; each result passes through the four register stages of its lane,
// Barrett reduction and then the Shoup multiply. All stages stall together while
// a result waits at the output, so req_tready follows rsp_tready in that case.
`default_nettype none

module ntt_twiddle_stage_mod_q
   import nts_pkg::*;
(
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_tvalid,
   output logic                req_tready,
   // a0, a1, a2, a3, b0, b1, b2, b3 from the lowest bit up, 32 bits each.
   input  wire  [IN_BUS-1:0]   req_tdata,
   output logic                rsp_tvalid,
   input  wire                 rsp_tready,
   // ya0, ya1, ya2, ya3, yb0, yb1, yb2, yb3 from the lowest bit up, 15 bits each.
   output logic [OUT_BUS-1:0]  rsp_tdata
);

   nts_ctrl_type ctrl;
   logic         pass;

   nts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .out_ready (rsp_tready),
      .in_ready  (req_tready),
      .out_valid (rsp_tvalid),
      .ctrl      (ctrl)
   );

   assign pass = (ctrl.grp_s2 == GRP_PASS);

   // Lanes j and j+4 share the twiddle of column j.
   for (genvar j = 0; j < LANES; j++) begin : g_lane
      nts_lane u_lane (
         .clock (clock),
         .en    (ctrl.en),
         .x     ($signed(req_tdata[j*IN_W +: IN_W])),
         .w     (TW_VAL[ctrl.grp_s2][j % COLS]),
         .wp    (TW_SHOUP[ctrl.grp_s2][j % COLS]),
         .pass  (pass),
         .y     (rsp_tdata[j*OUT_W +: OUT_W])
      );
   end

   a_grp_step : assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (ctrl.grp_cnt == GRP_W'($past(ctrl.grp_cnt) + 1'b1)))
      else $error("group counter did not advance on an accepted item");

   a_grp_hold : assert property (@(posedge clock) disable iff (reset)
      !(req_tvalid && req_tready) |=> $stable(ctrl.grp_cnt))
      else $error("group counter moved without an accepted item");

   a_out_src : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(ctrl.vld_s3))
      else $error("result appeared without an item in the third stage");

endmodule

`default_nettype wire

### bench/nts_stage_checker.sv
// Scoreboard for the modulo-12289 NTT twiddle stage: watches both stream channels,
// predicts every result from the accepted items and compares lane by lane.
// Depends on nts_pkg for the bus widths.
`timescale 1ns / 1ps

module nts_stage_checker
   import nts_pkg::*;
(
   input  wire                clock,
   input  wire                reset,
   input  wire                req_tvalid,
   input  wire                req_tready,
   // a0, a1, a2, a3, b0, b1, b2, b3 from the lowest bit up, 32 bits each.
   input  wire  [IN_BUS-1:0]  req_tdata,
   input  wire                rsp_tvalid,
   input  wire                rsp_tready,
   // ya0, ya1, ya2, ya3, yb0, yb1, yb2, yb3 from the lowest bit up, 15 bits each.
   input  wire  [OUT_BUS-1:0] rsp_tdata,
   output int                 fail_count,
   output int                 pending,
   output int                 checked
);

   localparam longint MODULUS      = 64'sd12289;
   localparam longint BARRETT_MULT = 64'sd349496;

   localparam longint TWIDDLE [4][4] = '{
      '{1, 1,    1,     1},
      '{1, 7506, 4134,  7260},
      '{1, 7260, 8246,  79},
      '{1, 4134, 11567, 8246}
   };

   localparam longint TWIDDLE_SHOUP [4][4] = '{
      '{87374, 87374,     87374,      87374},
      '{87374, 655830916, 361205037,  634336857},
      '{87374, 634336857, 720487841,  6902563},
      '{87374, 361205037, 1010657635, 720487841}
   };

   logic [OUT_BUS-1:0] expected_results [$];
   logic [GRP_W-1:0]   group_ctr;

   // Barrett reduction, then a Shoup multiply by the lane's twiddle outside group 0.
   // A negative coefficient can leave a negative remainder; it is carried on signed
   // and only its low bits reach the output.
   function automatic logic [OUT_W-1:0] reduce_lane(input logic [IN_W-1:0] coeff,
                                                    input logic [GRP_W-1:0] grp,
                                                    input int col);
      longint x;
      longint r;
      x = $signed(coeff);
      r = x - MODULUS * ((x * BARRETT_MULT) >>> 32);
      if (grp != GRP_PASS) begin
         r = r * TWIDDLE[grp][col]
             - MODULUS * ((r * TWIDDLE_SHOUP[grp][col]) >>> 30);
      end
      return r[OUT_W-1:0];
   endfunction

   function automatic logic [OUT_BUS-1:0] twiddle_item(input logic [IN_BUS-1:0] coeffs,
                                                       input logic [GRP_W-1:0] grp);
      logic [OUT_BUS-1:0] y;
      y = '0;
      for (int j = 0; j < LANES; j++) begin
         y[j*OUT_W +: OUT_W] = reduce_lane(coeffs[j*IN_W +: IN_W], grp, j % COLS);
      end
      return y;
   endfunction

   initial begin
      fail_count = 0;
      pending    = 0;
      checked    = 0;
      group_ctr  = '0;
   end

   always @(posedge clock) begin
      logic [OUT_BUS-1:0] want;
      if (reset) begin
         group_ctr = '0;
         expected_results.delete();
      end else begin
         // Results first, so that an item accepted at this edge cannot be matched.
         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0) begin
               $display("%0t: result %h arrived with no item outstanding", $time, rsp_tdata);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_results.pop_front();
               checked <= checked + 1;
               if (want !== rsp_tdata) begin
                  fail_count <= fail_count + 1;
                  for (int j = 0; j < LANES; j++) begin
                     if (want[j*OUT_W +: OUT_W] !== rsp_tdata[j*OUT_W +: OUT_W]) begin
                        $display("%0t: lane %0d expected %0d, got %0d", $time, j,
                                 want[j*OUT_W +: OUT_W], rsp_tdata[j*OUT_W +: OUT_W]);
                     end
                  end
               end
            end
         end
         if (req_tvalid && req_tready) begin
            expected_results.push_back(twiddle_item(req_tdata, group_ctr));
            group_ctr = group_ctr + 1'b1;
         end
      end
      pending <= expected_results.size();
   end

endmodule

### bench/tb.sv
// Testbench top for the modulo-12289 NTT twiddle stage: clock, reset, stimulus and
// the verdict. Instantiates ntt_twiddle_stage_mod_q and nts_stage_checker; uses nts_pkg.
`timescale 1ns / 1ps

module tb;
   import nts_pkg::*;

   logic               clock = 1'b0;
   logic               reset;
   logic               req_tvalid;
   logic               req_tready;
   logic [IN_BUS-1:0]  req_tdata;
   logic               rsp_tvalid;
   logic               rsp_tready;
   logic [OUT_BUS-1:0] rsp_tdata;
   int                 fail_count;
   int                 pending;
   int                 checked;
   logic               steady_flow;
   int                 items_sent;
   int                 negative_lanes;

   // Coefficients around the modulus, its multiples and the ends of the 32-bit range.
   int corner_coeffs [16] = '{0, 1, -1, 12288, 12289, 24577, 24578, -12289,
                              -12290, 32'h7FFF_FFFF, 32'h8000_0000, 65535,
                              -65536, 36867, -24578, 32'h4000_0000};

   ntt_twiddle_stage_mod_q i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   nts_stage_checker i_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .fail_count (fail_count),
      .pending    (pending),
      .checked    (checked)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (steady_flow || r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [IN_W-1:0] random_coeff();
      int v;
      case ($urandom_range(0, 5))
         0, 1: v = $urandom();
         2: v = $urandom_range(0, 24577);
         3: v = int'($urandom_range(0, 73734)) - 36867;
         4: begin
            v = 12289 * int'($urandom_range(0, 174000)) + int'($urandom_range(0, 2)) - 1;
            if ($urandom_range(0, 1)) v = -v;
         end
         default: v = corner_coeffs[$urandom_range(0, 15)];
      endcase
      return v;
   endfunction

   // Called at a falling edge; returns at the falling edge after the item is taken.
   task automatic send_coeffs(input logic [IN_BUS-1:0] coeffs);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= coeffs;
      for (int j = 0; j < LANES; j++) begin
         if (coeffs[j*IN_W + IN_W - 1]) negative_lanes++;
      end
      do @(posedge clock); while (!req_tready);
      items_sent++;
      @(negedge clock);
   endtask

   initial begin
      int gap;
      rsp_tready = 1'b0;
      wait (reset === 1'b0);
      forever begin
         gap = pick_gap();
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 8)) @(negedge clock);
      end
   end

   initial begin
      #4_000_000;
      $display("timeout with %0d results outstanding", pending);
      $display("ntt_twiddle_stage_mod_q: mismatch");
      $finish;
   end

   initial begin
      logic [IN_BUS-1:0] coeffs;
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      steady_flow    = 1'b0;
      items_sent     = 0;
      negative_lanes = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part: every corner value in every lane (each pairing meets one twiddle group),
      // led by all lanes at the largest and then the most negative coefficient.
      for (int k = 0; k < 22; k++) begin
         for (int j = 0; j < LANES; j++) begin
            if (k == 0)
               coeffs[j*IN_W +: IN_W] = 32'h7FFF_FFFF;
            else if (k == 1)
               coeffs[j*IN_W +: IN_W] = 32'h8000_0000;
            else
               coeffs[j*IN_W +: IN_W] = corner_coeffs[(k + 3 * j) % 16];
         end
         send_coeffs(coeffs);
      end

      for (int i = 0; i < 750; i++) begin
         if (i == 300) begin
            // Let the pipeline drain completely before carrying on.
            req_tvalid <= 1'b0;
            wait (pending == 0);
            @(negedge clock);
         end
         steady_flow = (i >= 450 && i < 600);
         for (int j = 0; j < LANES; j++) coeffs[j*IN_W +: IN_W] = random_coeff();
         send_coeffs(coeffs);
      end
      req_tvalid <= 1'b0;
      steady_flow = 1'b0;

      wait (pending == 0);
      repeat (12) @(posedge clock);
      $display("Sent %0d items through all four twiddle groups, %0d negative coefficients;",
               items_sent, negative_lanes);
      $display("%0d results compared with %0d failures.", checked, fail_count);
      if (fail_count == 0 && pending == 0) begin
         $display("ntt_twiddle_stage_mod_q: match");
      end else begin
         $display("ntt_twiddle_stage_mod_q: mismatch");
      end
      $finish;
   end

endmodule

### sim.f
hw/rtl/nts_pkg.sv
hw/rtl/nts_lane.sv
hw/rtl/nts_ctrl.sv
hw/rtl/ntt_twiddle_stage_mod_q.sv
bench/nts_stage_checker.sv
bench/tb.sv
